// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// ASSERT_RST: checked only while reset is released.
// ASSERT_ANY: checked at every clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ANY(label, clk, prop)
`endif

`endif

// ===== hdl/rrbm_pkg.sv =====
package rrbm_pkg;

    // widest cartridge RAM index (32 KiB)
    localparam int RAM_AW_MAX = 15;

    // result kinds
    localparam logic [1:0] KIND_ROM   = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // configuration register indexes
    localparam logic CFG_ROM_SIZE = 1'b0;
    localparam logic CFG_RAM_SIZE = 1'b1;

    // 8 KiB pages of the CPU bus, bus_address[15:13]
    localparam logic [2:0] PG_RAM_EN = 3'd0;
    localparam logic [2:0] PG_ROM_LO = 3'd1;
    localparam logic [2:0] PG_ROM_HI = 3'd2;
    localparam logic [2:0] PG_MODE   = 3'd3;
    localparam logic [2:0] PG_RAM    = 3'd5;

    localparam logic [4:0] ROM_LOG2_MIN = 5'd15;
    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [7:0] BYTE_NO_RAM  = 8'hFF;
    localparam logic [7:0] BYTE_OPEN    = 8'h00;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [RAM_AW_MAX-1:0] addr;
        logic [7:0]            wdata;
    } t_ram_req;

    // index mask for a RAM size code; code 0 means no RAM
    function automatic logic [RAM_AW_MAX-1:0] ram_mask(input logic [1:0] code);
        logic [RAM_AW_MAX-1:0] m;
        case (code)
            2'd1:    m = 15'h07FF;
            2'd2:    m = 15'h1FFF;
            2'd3:    m = 15'h7FFF;
            default: m = 15'h0000;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/rrbm_cart_ram.sv =====
module rrbm_cart_ram #(
    parameter int RAM_BYTES = 32768
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrbm_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata,
    output logic              o_busy
);
    import rrbm_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);
    localparam logic [AW-1:0] LastAddr = AW'(RAM_BYTES - 1);

    logic [7:0]    mem [RAM_BYTES];
    logic [7:0]    r_q;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] addr;

    assign addr = i_req.addr[AW-1:0];

    // zero one byte per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LastAddr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= 8'h00;
        end else if (i_req.we) begin
            mem[addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= mem[addr];
        end
    end

    assign o_rdata = r_q;
    assign o_busy  = r_clearing;

endmodule

// ===== hdl/rom_ram_bank_mapper.sv =====
// MBC1 style cartridge bank controller. One bus access enters per beat on the
// s_axis side and yields exactly one result beat on m_axis through stage 1 and
// the output register; a new access can be taken every cycle while the output
// side is ready. Writes below 0x8000 set the bank registers, writes to
// 0xA000-0xBFFF go to the on-chip cartridge RAM when it is enabled, reads of
// 0x0000-0x7FFF return the mapped ROM byte address and reads of 0xA000-0xBFFF
// return the RAM byte. The RAM is a single port synchronous memory whose
// registered read output is valid alongside stage 1. After reset the RAM is zeroed
// one byte per cycle and s_axis_tready stays low until that pass ends; configuration
// writes are taken at any time but should only be issued while no access is in flight.
`include "assert_macros.svh"

module rom_ram_bank_mapper #(
    parameter int RAM_BYTES     = 32768,
    parameter int ROM_ADDR_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_wdata,
    // bus access in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] bus_address, [23:16] write_data
    input  logic [0:0]  s_axis_tuser,   // [0] action
    // result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [20:0] rom_address, [28:21] read_data, zero pad
    output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);
    import rrbm_pkg::*;

    localparam logic [RAM_AW_MAX-1:0] RamCapMask = RAM_AW_MAX'(RAM_BYTES - 1);
    localparam logic [4:0]            RomLog2Max = 5'(ROM_ADDR_BITS);

    // configuration and bank registers
    logic [4:0] r_rom_log2;
    logic [1:0] r_ram_code;
    logic [4:0] r_low_bank;
    logic [1:0] r_hi_bits;
    logic       r_mode;
    logic       r_ram_en;

    // stage 1 (RAM read in flight) and output register
    logic        r_s1_valid;
    logic [1:0]  r_s1_kind;
    logic [20:0] r_s1_rom;
    logic        r_s1_ram_sel;
    logic [7:0]  r_s1_byte;
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [20:0] r_out_rom;
    logic [7:0]  r_out_data;

    logic                  in_acc;
    logic                  s1_adv;
    logic                  is_wr;
    logic [15:0]           bus_addr;
    logic [7:0]            wr_data;
    logic [2:0]            page;
    logic                  ram_present;
    logic [RAM_AW_MAX-1:0] ram_msk;
    logic [RAM_AW_MAX-1:0] ram_idx;
    logic [4:0]            rom_l;
    logic [20:0]           rom_msk;
    logic [6:0]            rom_bank;
    logic [20:0]           rom_addr;
    logic [1:0]            n_kind;
    logic                  n_ram_sel;
    logic [7:0]            n_byte;
    logic [7:0]            ram_q;
    logic                  ram_busy;
    t_ram_req              ram_req;

    assign is_wr    = s_axis_tuser[0];
    assign bus_addr = s_axis_tdata[15:0];
    assign wr_data  = s_axis_tdata[23:16];
    assign page     = bus_addr[15:13];

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !ram_busy && (!r_s1_valid || s1_adv);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // RAM index wraps to the effective size
    assign ram_msk     = ram_mask(r_ram_code) & RamCapMask;
    assign ram_present = (r_ram_code != 2'd0);
    assign ram_idx     = {(r_mode ? r_hi_bits : 2'b00), bus_addr[12:0]} & ram_msk;

    // ROM size saturates to the supported range
    always_comb begin
        if (r_rom_log2 < ROM_LOG2_MIN) begin
            rom_l = ROM_LOG2_MIN;
        end else if (r_rom_log2 > RomLog2Max) begin
            rom_l = RomLog2Max;
        end else begin
            rom_l = r_rom_log2;
        end
    end
    assign rom_msk = 21'((22'd1 << rom_l) - 22'd1);

    always_comb begin
        if (bus_addr[14]) begin
            rom_bank = {r_hi_bits, r_low_bank};
        end else begin
            rom_bank = r_mode ? {r_hi_bits, 5'd0} : 7'd0;
        end
    end
    assign rom_addr = {rom_bank, bus_addr[13:0]} & rom_msk;

    always_comb begin
        n_kind    = KIND_BYTE;
        n_ram_sel = 1'b0;
        n_byte    = BYTE_OPEN;
        if (is_wr) begin
            n_kind = KIND_WRITE;
        end else if (!bus_addr[15]) begin
            n_kind = KIND_ROM;
        end else if (page == PG_RAM) begin
            n_ram_sel = ram_present;
            n_byte    = ram_present ? BYTE_OPEN : BYTE_NO_RAM;
        end
    end

    assign ram_req.we    = in_acc && is_wr && (page == PG_RAM) && r_ram_en && ram_present;
    assign ram_req.re    = in_acc && !is_wr && (page == PG_RAM) && ram_present;
    assign ram_req.addr  = ram_idx;
    assign ram_req.wdata = wr_data;

    rrbm_cart_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_q),
        .o_busy  (ram_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_log2 <= ROM_LOG2_MIN;
            r_ram_code <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROM_SIZE: r_rom_log2 <= i_cfg_wdata;
                CFG_RAM_SIZE: r_ram_code <= i_cfg_wdata[1:0];
                default:      r_rom_log2 <= r_rom_log2;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_bank <= 5'd1;
            r_hi_bits  <= 2'd0;
            r_mode     <= 1'b0;
            r_ram_en   <= 1'b0;
        end else if (in_acc && is_wr) begin
            case (page)
                PG_RAM_EN: r_ram_en   <= (wr_data[3:0] == RAM_EN_KEY);
                PG_ROM_LO: r_low_bank <= (wr_data[4:0] == 5'd0) ? 5'd1 : wr_data[4:0];
                PG_ROM_HI: r_hi_bits  <= wr_data[1:0];
                PG_MODE:   r_mode     <= wr_data[0];
                default:   r_mode     <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind    <= n_kind;
            r_s1_rom     <= (n_kind == KIND_ROM) ? rom_addr : 21'd0;
            r_s1_ram_sel <= n_ram_sel;
            r_s1_byte    <= n_byte;
        end
        if (s1_adv) begin
            r_out_kind <= r_s1_kind;
            r_out_rom  <= r_s1_rom;
            r_out_data <= r_s1_ram_sel ? ram_q : r_s1_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {3'b000, r_out_data, r_out_rom};

    // no access enters while the RAM is being zeroed
    `ASSERT_RST(a_no_acc_clear, i_clk, i_rst_n, ram_busy |-> !s_axis_tready)
    // an accepted beat always lands in stage 1
    `ASSERT_RST(a_acc_to_s1, i_clk, i_rst_n, in_acc |=> r_s1_valid)
    // the low ROM bank never holds zero
    `ASSERT_RST(a_low_bank_nz, i_clk, i_rst_n, r_low_bank != 5'd0)
    // only ROM results carry an address, write results carry no byte
    `ASSERT_RST(a_out_fields, i_clk, i_rst_n,
        m_axis_tvalid |-> ((m_axis_tuser == KIND_ROM) || (m_axis_tdata[20:0] == 21'd0))
                       && ((m_axis_tuser != KIND_WRITE) || (m_axis_tdata[28:21] == 8'd0)))
    // RAM port never reads and writes in one cycle
    `ASSERT_ANY(a_ram_one_op, i_clk, !(ram_req.we && ram_req.re))

endmodule

// ===== verif/rom_ram_bank_mapper_test.sv =====
`timescale 1ns / 100ps

module rom_ram_bank_mapper_test;
    import rrbm_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [15:0] ADDR_RAM_EN    = 16'h0000;
    localparam logic [15:0] ADDR_ROM_BANK  = 16'h2000;
    localparam logic [15:0] ADDR_HIGH_BITS = 16'h4000;
    localparam logic [15:0] ADDR_MODE      = 16'h6000;
    localparam logic [15:0] ADDR_VIDEO     = 16'h8000;
    localparam logic [15:0] ADDR_CART_RAM  = 16'hA000;
    localparam logic [15:0] ADDR_UPPER     = 16'hC000;

    localparam int RAM_DEPTH   = 32768;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 150;
    // the limit covers the RAM clearing pass after reset, which keeps the input side closed
    localparam int IDLE_LIMIT  = 150000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] rom_addr;
        logic [7:0]  rdata;
    } t_bus_result;

    class mapper_board;
        logic [4:0]  rom_log2;
        logic [1:0]  ram_code;
        logic [4:0]  low_bank;
        logic [1:0]  high_bits;
        logic        adv_mode;
        logic        ram_on;
        logic [7:0]  cart_mem [RAM_DEPTH];
        t_bus_result due_results [$];
        int          errors;

        function new();
            rom_log2  = ROM_LOG2_MIN;
            ram_code  = 2'd0;
            low_bank  = 5'd1;
            high_bits = 2'd0;
            adv_mode  = 1'b0;
            ram_on    = 1'b0;
            errors    = 0;
            foreach (cart_mem[i]) cart_mem[i] = 8'h00;
        endfunction

        function void write_reg(logic idx, logic [4:0] value);
            if (idx == CFG_ROM_SIZE) rom_log2 = value;
            else ram_code = value[1:0];
        endfunction

        function int unsigned ram_bytes();
            case (ram_code)
                2'd1:    return 2048;
                2'd2:    return 8192;
                2'd3:    return 32768;
                default: return 0;
            endcase
        endfunction

        function int unsigned ram_slot(logic [15:0] addr, int unsigned size);
            int unsigned bank;
            bank = adv_mode ? int'(high_bits) : 0;
            return (bank * 32'h2000 + (int'(addr) - 32'hA000)) % size;
        endfunction

        function void take_access(logic wr, logic [15:0] addr, logic [7:0] data);
            t_bus_result r;
            int unsigned size;
            int unsigned bank;
            int unsigned l;
            int unsigned mask;
            r    = '0;
            size = ram_bytes();
            l    = 32'(rom_log2);
            if (l < 15) l = 15;
            if (l > 21) l = 21;
            mask = (32'd1 << l) - 1;
            if (wr) begin
                r.kind = KIND_WRITE;
                if (addr < ADDR_ROM_BANK) begin
                    ram_on = (data[3:0] == RAM_EN_KEY);
                end else if (addr < ADDR_HIGH_BITS) begin
                    low_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
                end else if (addr < ADDR_MODE) begin
                    high_bits = data[1:0];
                end else if (addr < ADDR_VIDEO) begin
                    adv_mode = data[0];
                end else if (addr >= ADDR_CART_RAM && addr < ADDR_UPPER) begin
                    if (ram_on && size != 0) cart_mem[15'(ram_slot(addr, size))] = data;
                end
            end else if (addr < ADDR_HIGH_BITS) begin
                r.kind     = KIND_ROM;
                bank       = adv_mode ? (int'(high_bits) << 5) : 0;
                r.rom_addr = 21'((bank * 32'h4000 + int'(addr)) & mask);
            end else if (addr < ADDR_VIDEO) begin
                r.kind     = KIND_ROM;
                bank       = (int'(high_bits) << 5) | int'(low_bank);
                r.rom_addr = 21'((bank * 32'h4000 + (int'(addr) - 32'h4000)) & mask);
            end else if (addr >= ADDR_CART_RAM && addr < ADDR_UPPER) begin
                r.kind  = KIND_BYTE;
                r.rdata = (size == 0) ? BYTE_NO_RAM : cart_mem[15'(ram_slot(addr, size))];
            end else begin
                r.kind  = KIND_BYTE;
                r.rdata = BYTE_OPEN;
            end
            due_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] kind, logic [20:0] rom_addr, logic [7:0] rdata);
            t_bus_result want;
            if (due_results.size() == 0) begin
                $error("unexpected result: result_kind %0d rom_address 0x%0h read_data 0x%0h",
                       kind, rom_addr, rdata);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (rom_addr !== want.rom_addr) begin
                $error("rom_address: expected 0x%0h, actual 0x%0h", want.rom_addr, rom_addr);
                errors++;
            end
            if (rdata !== want.rdata) begin
                $error("read_data: expected 0x%0h, actual 0x%0h", want.rdata, rdata);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [15:0] bus_address, [23:16] write_data
    logic [0:0]  s_axis_tuser;   // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [20:0] rom_address, [28:21] read_data, zero pad
    logic [1:0]  m_axis_tuser;   // [1:0] result_kind

    mapper_board board = new();
    bit          steady = 1'b0;
    int          idle_cycles = 0;

    rom_ram_bank_mapper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // hold one beat until the block takes it, then log it for prediction
    task automatic send_access(logic wr, logic [15:0] addr, logic [7:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= wr;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_access(wr, addr, data);
    endtask

    // drain all results, then program both size registers
    task automatic set_config(logic [4:0] rom_log2, logic [1:0] ram_code);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_ROM_SIZE;
        i_cfg_wdata <= rom_log2;
        @(posedge i_clk);
        board.write_reg(CFG_ROM_SIZE, rom_log2);
        i_cfg_idx   <= CFG_RAM_SIZE;
        i_cfg_wdata <= {3'b000, ram_code};
        @(posedge i_clk);
        board.write_reg(CFG_RAM_SIZE, {3'b000, ram_code});
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [15:0] off;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        off  = 16'($urandom_range(0, 16'h1FFF));
        data = 8'($urandom_range(0, 255));
        if (pick < 10) begin
            // mostly valid enable keys so RAM writes get through
            if ($urandom_range(0, 3) != 0) data[3:0] = RAM_EN_KEY;
            send_access(ACT_WRITE, ADDR_RAM_EN + off, data);
        end else if (pick < 20) begin
            if ($urandom_range(0, 4) == 0) data[4:0] = 5'd0;
            send_access(ACT_WRITE, ADDR_ROM_BANK + off, data);
        end else if (pick < 28) begin
            send_access(ACT_WRITE, ADDR_HIGH_BITS + off, data);
        end else if (pick < 34) begin
            send_access(ACT_WRITE, ADDR_MODE + off, data);
        end else if (pick < 54) begin
            send_access(ACT_WRITE, ADDR_CART_RAM + off, data);
        end else if (pick < 74) begin
            send_access(ACT_READ, ADDR_CART_RAM + off, data);
        end else if (pick < 84) begin
            send_access(ACT_READ, 16'($urandom_range(0, 16'h3FFF)), data);
        end else if (pick < 94) begin
            send_access(ACT_READ, ADDR_HIGH_BITS + 16'($urandom_range(0, 16'h3FFF)), data);
        end else if ($urandom_range(0, 1) == 0) begin
            send_access(1'($urandom_range(0, 1)), ADDR_VIDEO + off, data);
        end else begin
            send_access(1'($urandom_range(0, 1)),
                        ADDR_UPPER + 16'($urandom_range(0, 16'h3FFF)), data);
        end
    endtask

    // result side: random stall before each beat
    initial begin
        int stall;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata[20:0], m_axis_tdata[28:21]);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [4:0] rom_sel [5];
        logic [1:0] ram_sel [5];
        logic [4:0] rom_log2;
        logic [1:0] ram_code;
        rom_sel = '{5'd21, 5'd15, 5'd0, 5'd31, 5'd18};
        ram_sel = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3};

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ROM_SIZE;
        i_cfg_wdata   <= 5'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: no RAM, 32 KiB ROM
        send_access(ACT_READ,  ADDR_CART_RAM, 8'h00);
        send_access(ACT_WRITE, ADDR_RAM_EN,   8'h0A);
        send_access(ACT_WRITE, ADDR_CART_RAM, 8'h12);
        send_access(ACT_READ,  16'h7FFF,      8'hFF);

        set_config(5'd21, 2'd3);
        send_access(ACT_READ,  ADDR_CART_RAM, 8'h00);
        send_access(ACT_WRITE, ADDR_RAM_EN,   8'h00);
        // disabled RAM: write dropped, read still returns the stored byte
        send_access(ACT_WRITE, 16'hA123, 8'h55);
        send_access(ACT_READ,  16'hA123, 8'h00);
        send_access(ACT_WRITE, 16'h1FFF, 8'hFA);
        send_access(ACT_WRITE, 16'hA123, 8'h55);
        send_access(ACT_READ,  16'hA123, 8'h00);
        // zero low bank reads as bank one
        send_access(ACT_WRITE, ADDR_ROM_BANK, 8'h00);
        send_access(ACT_READ,  ADDR_HIGH_BITS, 8'h00);
        send_access(ACT_WRITE, 16'h3FFF, 8'hFF);
        send_access(ACT_WRITE, 16'h5FFF, 8'hFF);
        send_access(ACT_READ,  16'h7FFF, 8'h00);
        send_access(ACT_READ,  16'h0000, 8'h00);
        send_access(ACT_WRITE, 16'h7FFF, 8'hFF);
        send_access(ACT_READ,  16'h3FFF, 8'h00);
        send_access(ACT_WRITE, 16'hBFFF, 8'hFF);
        send_access(ACT_READ,  16'hBFFF, 8'h00);
        send_access(ACT_READ,  ADDR_VIDEO, 8'h00);
        send_access(ACT_READ,  16'hFFFF, 8'hFF);
        send_access(ACT_WRITE, ADDR_UPPER, 8'h00);
        send_access(ACT_WRITE, ADDR_MODE, 8'hFE);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                rom_log2 = rom_sel[p];
                ram_code = ram_sel[p];
            end else begin
                rom_log2 = 5'($urandom_range(0, 31));
                ram_code = 2'($urandom_range(0, 3));
            end
            set_config(rom_log2, ram_code);
            steady = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random();
            steady = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rrbm_pkg.sv
hdl/rrbm_cart_ram.sv
hdl/rom_ram_bank_mapper.sv
verif/rom_ram_bank_mapper_test.sv
